@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the envelope RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked at every rising edge outside reset.
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ rtl/core/adsr_pkg.sv @@
// Shared types, constants and register codes of the ADSR envelope generator.
// No dependencies; used by adsr_div, adsr_envelope, adsr_checker and the testbench.
package adsr_pkg;
   localparam int TIME_W  = 32;
   localparam int LEVEL_W = 16;
   localparam int PHASE_W = 3;
   localparam int NUM_W   = TIME_W + LEVEL_W;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'd32768;

   localparam logic [PHASE_W-1:0] PH_OFF     = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
   localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;
   localparam logic [PHASE_W-1:0] PH_BYPASS  = 3'd5;

   localparam logic [2:0] REG_ATTACK  = 3'd0;
   localparam logic [2:0] REG_DECAY   = 3'd1;
   localparam logic [2:0] REG_RELEASE = 3'd2;
   localparam logic [2:0] REG_PEAK    = 3'd3;
   localparam logic [2:0] REG_HOLD    = 3'd4;
   localparam logic [2:0] REG_KEYDOWN = 3'd5;
   localparam logic [2:0] REG_KEYUP   = 3'd6;
   localparam logic [2:0] REG_BYPASS  = 3'd7;

   localparam logic [TIME_W-1:0]  RST_ATTACK  = 32'd655;
   localparam logic [TIME_W-1:0]  RST_DECAY   = 32'd655;
   localparam logic [TIME_W-1:0]  RST_RELEASE = 32'd1311;
   localparam logic [LEVEL_W-1:0] RST_PEAK    = 16'd32768;
   localparam logic [LEVEL_W-1:0] RST_HOLD    = 16'd26214;
   localparam logic [TIME_W-1:0]  RST_KEYDOWN = 32'd0;
   localparam logic [TIME_W-1:0]  RST_KEYUP   = 32'd65536;

   typedef struct packed {
      logic [NUM_W-1:0]   num;
      logic [TIME_W-1:0]  den;
      logic [PHASE_W-1:0] phase;
   } div_req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] quot;
      logic [PHASE_W-1:0] phase;
   } div_rsp_type;
endpackage

@@ rtl/core/adsr_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on adsr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module adsr_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  adsr_pkg::div_req_type in_req,
   output logic                out_valid,
   output adsr_pkg::div_rsp_type out_rsp
);
   localparam int NST = adsr_pkg::LEVEL_W;
   localparam int NW  = adsr_pkg::NUM_W;
   localparam int DW  = adsr_pkg::TIME_W;
   localparam int QW  = adsr_pkg::LEVEL_W;
   localparam int PW  = adsr_pkg::PHASE_W;

   logic          valid_ff [NST];
   logic [NW-1:0] rem_ff   [NST];
   logic [DW-1:0] den_ff   [NST];
   logic [QW-1:0] quot_ff  [NST];
   logic [PW-1:0] phase_ff [NST];

   for (genvar k = 0; k < NST; k++) begin : g_stage
      localparam int B = NST - 1 - k;
      logic          src_valid;
      logic [NW-1:0] src_rem;
      logic [DW-1:0] src_den;
      logic [QW-1:0] src_quot;
      logic [PW-1:0] src_phase;
      logic [NW-1:0] shifted;
      logic          ge;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quot_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_req.num;
         assign src_den   = in_req.den;
         assign src_quot  = '0;
         assign src_phase = in_req.phase;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_quot  = quot_ff[k-1];
         assign src_phase = phase_ff[k-1];
      end

      assign shifted = {{(NW-DW){1'b0}}, src_den} << B;
      assign ge      = src_rem >= shifted;
      assign rem_in  = ge ? (src_rem - shifted) : src_rem;
      assign quot_in = src_quot | ({{(QW-1){1'b0}}, ge} << B);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]   <= rem_in;
            den_ff[k]   <= src_den;
            quot_ff[k]  <= quot_in;
            phase_ff[k] <= src_phase;
         end
      end
   end

   assign out_valid     = valid_ff[NST-1];
   assign out_rsp.quot  = quot_ff[NST-1];
   assign out_rsp.phase = phase_ff[NST-1];

   // A held result stays presented while the pipeline is frozen.
   `CHK_NEXT(a_div_hold, clock, reset, out_valid && !adv, out_valid)
   // The quotient never exceeds full level.
   `CHK_IMPLY(a_div_range, clock, reset, out_valid, out_rsp.quot <= adsr_pkg::FULL_LEVEL)
endmodule

@@ rtl/core/adsr_envelope.sv @@
// Top level of the linear ADSR envelope generator with its register file.
// Depends on adsr_pkg, adsr_div and assert_macros.svh.
//
// The block maps one note time (Q16.16 seconds) to one envelope level (Q1.15,
// 32768 = 1.0) and a phase code, and accepts a new transaction every cycle
// while req_stall is low. One stage decodes the phase and picks the operands,
// one stage forms two 16x32 products, one stage sums them, and a 16-stage
// restoring divider produces one quotient bit per stage. The pipeline moves
// as a whole; it freezes only while a result is presented and rsp_stall is
// high, so req_stall mirrors that condition and no transaction is lost.
// Registers sit at byte address 4*index on the APB-style port (attack,
// decay, release lengths, peak and hold levels, key-down and key-up times,
// bypass) and should only be written while the pipeline holds no work.
`include "assert_macros.svh"
module adsr_envelope (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [adsr_pkg::TIME_W-1:0]          req_note_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [adsr_pkg::LEVEL_W-1:0]         rsp_level,
   output logic [adsr_pkg::PHASE_W-1:0]         rsp_phase,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [adsr_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [adsr_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [adsr_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                 csr_pready
);
   localparam int TW = adsr_pkg::TIME_W;
   localparam int LW = adsr_pkg::LEVEL_W;
   localparam int PW = adsr_pkg::PHASE_W;
   localparam int NW = adsr_pkg::NUM_W;

   // Configuration registers.
   logic [TW-1:0] attack_ff, decay_ff, release_ff, keydown_ff, keyup_ff;
   logic [LW-1:0] peak_ff, hold_ff;
   logic          bypass_ff;
   logic [2:0]    csr_idx;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= adsr_pkg::RST_ATTACK;
         decay_ff   <= adsr_pkg::RST_DECAY;
         release_ff <= adsr_pkg::RST_RELEASE;
         peak_ff    <= adsr_pkg::RST_PEAK;
         hold_ff    <= adsr_pkg::RST_HOLD;
         keydown_ff <= adsr_pkg::RST_KEYDOWN;
         keyup_ff   <= adsr_pkg::RST_KEYUP;
         bypass_ff  <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            adsr_pkg::REG_ATTACK:  attack_ff  <= csr_pwdata;
            adsr_pkg::REG_DECAY:   decay_ff   <= csr_pwdata;
            adsr_pkg::REG_RELEASE: release_ff <= csr_pwdata;
            adsr_pkg::REG_PEAK:    peak_ff    <= csr_pwdata[LW-1:0];
            adsr_pkg::REG_HOLD:    hold_ff    <= csr_pwdata[LW-1:0];
            adsr_pkg::REG_KEYDOWN: keydown_ff <= csr_pwdata;
            adsr_pkg::REG_KEYUP:   keyup_ff   <= csr_pwdata;
            adsr_pkg::REG_BYPASS:  bypass_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         adsr_pkg::REG_ATTACK:  csr_prdata = attack_ff;
         adsr_pkg::REG_DECAY:   csr_prdata = decay_ff;
         adsr_pkg::REG_RELEASE: csr_prdata = release_ff;
         adsr_pkg::REG_PEAK:    csr_prdata = {16'd0, peak_ff};
         adsr_pkg::REG_HOLD:    csr_prdata = {16'd0, hold_ff};
         adsr_pkg::REG_KEYDOWN: csr_prdata = keydown_ff;
         adsr_pkg::REG_KEYUP:   csr_prdata = keyup_ff;
         adsr_pkg::REG_BYPASS:  csr_prdata = {31'd0, bypass_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // The whole pipeline advances unless a presented result is held back.
   logic adv;
   logic accept;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   // Stage 1: phase decision and operand selection. The level is always
   // (x1*y1 + x2*y2) / den, with den = 1 for the constant cases.
   logic [LW-1:0] peak_sat, hold_sat;
   logic [TW-1:0] r_time, d_time, e_time;
   logic [TW:0]   decay_end;
   logic [LW-1:0] x1_in, x2_in;
   logic [TW-1:0] y1_in, y2_in, den_in;
   logic [PW-1:0] ph_in;

   assign peak_sat  = (peak_ff > adsr_pkg::FULL_LEVEL) ? adsr_pkg::FULL_LEVEL : peak_ff;
   assign hold_sat  = (hold_ff > adsr_pkg::FULL_LEVEL) ? adsr_pkg::FULL_LEVEL : hold_ff;
   assign r_time    = req_note_time - keyup_ff;
   assign d_time    = req_note_time - keydown_ff;
   assign e_time    = d_time - attack_ff;
   assign decay_end = {1'b0, attack_ff} + {1'b0, decay_ff};

   always_comb begin
      x1_in  = '0;
      y1_in  = '0;
      x2_in  = '0;
      y2_in  = '0;
      den_in = {{(TW-1){1'b0}}, 1'b1};
      ph_in  = adsr_pkg::PH_OFF;
      if (bypass_ff) begin
         x1_in = adsr_pkg::FULL_LEVEL;
         y1_in = {{(TW-1){1'b0}}, 1'b1};
         ph_in = adsr_pkg::PH_BYPASS;
      end else if (req_note_time > keyup_ff) begin
         // Release wins over everything but bypass, even before the press.
         if (release_ff != '0 && r_time <= release_ff) begin
            x1_in  = hold_sat;
            y1_in  = release_ff - r_time;
            den_in = release_ff;
            ph_in  = adsr_pkg::PH_RELEASE;
         end
      end else if (req_note_time >= keydown_ff) begin
         if (d_time < attack_ff) begin
            x1_in  = peak_sat;
            y1_in  = d_time;
            den_in = attack_ff;
            ph_in  = adsr_pkg::PH_ATTACK;
         end else if ({1'b0, d_time} < decay_end) begin
            x1_in  = peak_sat;
            y1_in  = decay_ff - e_time;
            x2_in  = hold_sat;
            y2_in  = e_time;
            den_in = decay_ff;
            ph_in  = adsr_pkg::PH_DECAY;
         end else begin
            x1_in = hold_sat;
            y1_in = {{(TW-1){1'b0}}, 1'b1};
            ph_in = adsr_pkg::PH_SUSTAIN;
         end
      end
   end

   logic          s1_valid_ff;
   logic [LW-1:0] s1_x1_ff, s1_x2_ff;
   logic [TW-1:0] s1_y1_ff, s1_y2_ff, s1_den_ff;
   logic [PW-1:0] s1_ph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x1_ff  <= x1_in;
         s1_y1_ff  <= y1_in;
         s1_x2_ff  <= x2_in;
         s1_y2_ff  <= y2_in;
         s1_den_ff <= den_in;
         s1_ph_ff  <= ph_in;
      end
   end

   // Stage 2: the two products, each registered before they are added.
   logic          s2_valid_ff;
   logic [NW-1:0] s2_p1_ff, s2_p2_ff;
   logic [TW-1:0] s2_den_ff;
   logic [PW-1:0] s2_ph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_p1_ff  <= NW'(s1_x1_ff) * NW'(s1_y1_ff);
         s2_p2_ff  <= NW'(s1_x2_ff) * NW'(s1_y2_ff);
         s2_den_ff <= s1_den_ff;
         s2_ph_ff  <= s1_ph_ff;
      end
   end

   // Stage 3: the numerator. The decay sum never exceeds full level times
   // the decay length, so it fits without a carry out.
   logic                  s3_valid_ff;
   adsr_pkg::div_req_type s3_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_req_ff.num   <= s2_p1_ff + s2_p2_ff;
         s3_req_ff.den   <= s2_den_ff;
         s3_req_ff.phase <= s2_ph_ff;
      end
   end

   // Divider stages; the last one is the output register.
   adsr_pkg::div_rsp_type div_rsp;

   adsr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s3_valid_ff),
      .in_req    (s3_req_ff),
      .out_valid (rsp_valid),
      .out_rsp   (div_rsp)
   );

   assign rsp_level = div_rsp.quot;
   assign rsp_phase = div_rsp.phase;

   // An off result always carries a zero level.
   `CHK_IMPLY(a_off_zero, clock, reset, rsp_valid && rsp_phase == adsr_pkg::PH_OFF, rsp_level == '0)
   // A bypass result always carries full level.
   `CHK_IMPLY(a_bypass_full, clock, reset, rsp_valid && rsp_phase == adsr_pkg::PH_BYPASS, rsp_level == adsr_pkg::FULL_LEVEL)
   // Input is refused only when a presented result is held back.
   `CHK_IMPLY(a_stall_link, clock, reset, req_stall, rsp_valid && rsp_stall)
endmodule

@@ verif/adsr_checker.sv @@
// Scoreboard for the ADSR envelope: it snoops register writes, predicts each
// level and phase, and compares results in order. Depends on adsr_pkg.
`timescale 1ns / 1ps
module adsr_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [adsr_pkg::TIME_W-1:0]   req_note_time,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [adsr_pkg::LEVEL_W-1:0]  rsp_level,
   input  logic [adsr_pkg::PHASE_W-1:0]  rsp_phase,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic                          csr_pready,
   input  logic [adsr_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [adsr_pkg::DATA_W-1:0]   csr_pwdata,
   output int                            fail_count,
   output int                            pending,
   output int                            checked
);
   localparam int TW = adsr_pkg::TIME_W;
   localparam int LW = adsr_pkg::LEVEL_W;
   localparam int PW = adsr_pkg::PHASE_W;

   typedef struct packed {
      logic [LW-1:0] level;
      logic [PW-1:0] phase;
   } envelope_point_type;

   logic [TW-1:0] attack_len, decay_len, release_len, down_time, up_time;
   logic [LW-1:0] peak_reg, hold_reg;
   logic          bypass_on;

   envelope_point_type expected_points[$];
   int                 mismatches;
   int                 compared;

   assign fail_count = mismatches;
   assign pending    = expected_points.size();
   assign checked    = compared;

   function automatic envelope_point_type envelope_at(logic [TW-1:0] t);
      longint unsigned    peak, hold, d, r, e, quotient;
      envelope_point_type p;
      peak = (peak_reg > adsr_pkg::FULL_LEVEL) ? adsr_pkg::FULL_LEVEL : peak_reg;
      hold = (hold_reg > adsr_pkg::FULL_LEVEL) ? adsr_pkg::FULL_LEVEL : hold_reg;
      p.level = '0;
      p.phase = adsr_pkg::PH_OFF;
      if (bypass_on) begin
         p.level = adsr_pkg::FULL_LEVEL;
         p.phase = adsr_pkg::PH_BYPASS;
      end else if (t > up_time) begin
         r = t - up_time;
         if (release_len != 0 && r <= release_len) begin
            quotient = hold * (release_len - r) / release_len;
            p.level = quotient[LW-1:0];
            p.phase = adsr_pkg::PH_RELEASE;
         end
      end else if (t >= down_time) begin
         d = t - down_time;
         // The end of decay needs 33 bits, which 64-bit math covers.
         if (d < attack_len) begin
            quotient = peak * d / attack_len;
            p.phase = adsr_pkg::PH_ATTACK;
         end else if (d < longint'(attack_len) + longint'(decay_len)) begin
            e = d - attack_len;
            quotient = (peak * (decay_len - e) + hold * e) / decay_len;
            p.phase = adsr_pkg::PH_DECAY;
         end else begin
            quotient = hold;
            p.phase = adsr_pkg::PH_SUSTAIN;
         end
         p.level = quotient[LW-1:0];
      end
      return p;
   endfunction

   always @(posedge clock) begin
      envelope_point_type want;
      if (reset) begin
         attack_len  <= adsr_pkg::RST_ATTACK;
         decay_len   <= adsr_pkg::RST_DECAY;
         release_len <= adsr_pkg::RST_RELEASE;
         peak_reg    <= adsr_pkg::RST_PEAK;
         hold_reg    <= adsr_pkg::RST_HOLD;
         down_time   <= adsr_pkg::RST_KEYDOWN;
         up_time     <= adsr_pkg::RST_KEYUP;
         bypass_on   <= 1'b0;
         expected_points.delete();
         mismatches  <= 0;
         compared    <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_points.push_back(envelope_at(req_note_time));
         if (rsp_valid && !rsp_stall) begin
            compared <= compared + 1;
            if (expected_points.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("[%0t] unexpected result level=%0d phase=%0d",
                           $realtime, rsp_level, rsp_phase);
            end else begin
               want = expected_points.pop_front();
               if (want.level !== rsp_level || want.phase !== rsp_phase) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display({"[%0t] mismatch: expected level=%0d phase=%0d,",
                               " got level=%0d phase=%0d"},
                              $realtime, want.level, want.phase, rsp_level, rsp_phase);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               adsr_pkg::REG_ATTACK:  attack_len  <= csr_pwdata;
               adsr_pkg::REG_DECAY:   decay_len   <= csr_pwdata;
               adsr_pkg::REG_RELEASE: release_len <= csr_pwdata;
               adsr_pkg::REG_PEAK:    peak_reg    <= csr_pwdata[LW-1:0];
               adsr_pkg::REG_HOLD:    hold_reg    <= csr_pwdata[LW-1:0];
               adsr_pkg::REG_KEYDOWN: down_time   <= csr_pwdata;
               adsr_pkg::REG_KEYUP:   up_time     <= csr_pwdata;
               adsr_pkg::REG_BYPASS:  bypass_on   <= csr_pwdata[0];
               default: ;
            endcase
         end
      end
   end
endmodule

@@ verif/testbench.sv @@
// Top of the ADSR envelope testbench: clock, reset, stimulus and verdict.
// Depends on adsr_pkg, adsr_envelope and adsr_checker.
`timescale 1ns / 1ps
module testbench;
   localparam int TW = adsr_pkg::TIME_W;

   // The run is far shorter than this; hitting it means the block hung.
   localparam int CYCLE_LIMIT = 400000;

   logic                          clock;
   logic                          reset;
   logic                          req_valid, req_stall, rsp_valid, rsp_stall;
   logic [TW-1:0]                 req_note_time;
   logic [adsr_pkg::LEVEL_W-1:0]  rsp_level;
   logic [adsr_pkg::PHASE_W-1:0]  rsp_phase;
   logic                          csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [adsr_pkg::ADDR_W-1:0]   csr_paddr;
   logic [adsr_pkg::DATA_W-1:0]   csr_pwdata, csr_prdata;

   int fail_count, pending, checked;
   int cycles;
   int sent;
   int send_idle_pct, recv_stall_pct;
   int settings_run;

   // Our own copy of what was written, used only to aim note times at edges.
   logic [31:0] shadow[8];

   adsr_envelope dut (.*);

   adsr_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_note_time,
      .rsp_valid, .rsp_stall, .rsp_level, .rsp_phase,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .fail_count, .pending, .checked
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: a hang ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // The receiver stalls at random, at the rate set by the current mode.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Idle pattern follows the progress of the stimulus: first the sender idles
   // more lightly than the receiver stalls, then the reverse, then neither.
   always_comb begin
      if (sent < 650) begin
         send_idle_pct  = 36;
         recv_stall_pct = 61;
      end else if (sent < 1300) begin
         send_idle_pct  = 61;
         recv_stall_pct = 36;
      end else begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
   end

   // Offers one note time and holds it until the block takes the transaction.
   // Valid is only lowered when an idle cycle is actually inserted.
   task automatic send_time(input logic [TW-1:0] t);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_note_time <= t;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // Lets every outstanding result come back, then idles longer so that the
   // pipeline is certainly empty before registers are touched.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // APB write: a setup phase, then the access phase that commits the data.
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      shadow[index] = value;
   endtask

   task automatic load_envelope(input logic [31:0] atk, dec, rel, peak, hold,
                                input logic [31:0] down, up, byp);
      drain();
      csr_write(adsr_pkg::REG_ATTACK, atk);
      csr_write(adsr_pkg::REG_DECAY, dec);
      csr_write(adsr_pkg::REG_RELEASE, rel);
      csr_write(adsr_pkg::REG_PEAK, peak);
      csr_write(adsr_pkg::REG_HOLD, hold);
      csr_write(adsr_pkg::REG_KEYDOWN, down);
      csr_write(adsr_pkg::REG_KEYUP, up);
      csr_write(adsr_pkg::REG_BYPASS, byp);
      settings_run++;
   endtask

   // Draws a length that is usually short, sometimes zero or huge.
   function automatic logic [31:0] pick_length();
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return $urandom();
         2:       return 32'hFFFF_FFFF;
         3:       return $urandom_range(1, 8);
         default: return $urandom_range(1, 70000);
      endcase
   endfunction

   function automatic logic [31:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return {16'd0, adsr_pkg::FULL_LEVEL};
         1:       return 32'd0;
         2:       return $urandom_range(0, 16'hFFFF);
         default: return $urandom_range(0, adsr_pkg::FULL_LEVEL);
      endcase
   endfunction

   // Most note times land inside or near a phase of the current envelope, so
   // every interpolation and its boundaries get exercised; the rest are noise.
   function automatic logic [31:0] pick_time();
      logic [31:0] down, up, atk, dec, rel, jitter;
      down   = shadow[adsr_pkg::REG_KEYDOWN];
      up     = shadow[adsr_pkg::REG_KEYUP];
      atk    = shadow[adsr_pkg::REG_ATTACK];
      dec    = shadow[adsr_pkg::REG_DECAY];
      rel    = shadow[adsr_pkg::REG_RELEASE];
      jitter = $urandom_range(0, 4) - 2;
      case ($urandom_range(0, 9))
         0, 1: return $urandom();
         2:    return down + $urandom_range(0, atk);
         3:    return down + atk + $urandom_range(0, dec);
         4:    return up + $urandom_range(0, rel);
         5:    return down + jitter;
         6:    return down + atk + jitter;
         7:    return down + atk + dec + jitter;
         8:    return up + jitter;
         default: return up + rel + jitter;
      endcase
   endfunction

   task automatic random_burst(input int count);
      repeat (count) send_time(pick_time());
   endtask

   initial begin
      cycles        = 0;
      sent          = 0;
      settings_run  = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_note_time = '0;
      rsp_stall     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      shadow[adsr_pkg::REG_ATTACK]  = adsr_pkg::RST_ATTACK;
      shadow[adsr_pkg::REG_DECAY]   = adsr_pkg::RST_DECAY;
      shadow[adsr_pkg::REG_RELEASE] = adsr_pkg::RST_RELEASE;
      shadow[adsr_pkg::REG_PEAK]    = {16'd0, adsr_pkg::RST_PEAK};
      shadow[adsr_pkg::REG_HOLD]    = {16'd0, adsr_pkg::RST_HOLD};
      shadow[adsr_pkg::REG_KEYDOWN] = adsr_pkg::RST_KEYDOWN;
      shadow[adsr_pkg::REG_KEYUP]   = adsr_pkg::RST_KEYUP;
      shadow[adsr_pkg::REG_BYPASS]  = 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset envelope: each phase edge, the end of release and the extremes.
      send_time(32'd0);
      send_time(32'd1);
      send_time(32'd327);
      send_time(32'd654);
      send_time(32'd655);
      send_time(32'd1000);
      send_time(32'd1309);
      send_time(32'd1310);
      send_time(32'd65536);
      send_time(32'd65537);
      send_time(32'd66000);
      send_time(32'd66847);
      send_time(32'd66848);
      send_time(32'hFFFF_FFFF);
      // Hold off until everything is back before going on.
      drain();

      // Zero lengths skip attack and decay, release ends at once, and the
      // level registers above full scale saturate.
      load_envelope(0, 0, 0, 32'hFFFF, 32'h8001, 100, 200, 0);
      send_time(32'd99);
      send_time(32'd100);
      send_time(32'd200);
      send_time(32'd201);
      // Longest lengths: the end of decay needs a 33rd bit.
      load_envelope(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    {16'd0, adsr_pkg::FULL_LEVEL}, 0, 0, 32'hFFFF_FFFE, 0);
      send_time(32'hFFFF_FFFE);
      send_time(32'hFFFF_FFFF);
      send_time(32'h8000_0000);
      // Key-up before key-down: release takes priority over the off region and attack.
      load_envelope(300, 300, 1000, {16'd0, adsr_pkg::FULL_LEVEL}, 16000, 1000, 50, 0);
      send_time(32'd51);
      send_time(32'd999);
      send_time(32'd1001);
      // Bypass overrides everything else.
      load_envelope(300, 300, 1000, 0, 0, 1000, 50, 1);
      send_time(32'd0);
      send_time(32'd60);
      random_burst(60);

      // Random envelopes, each with a run of note times aimed at its phases.
      repeat (11) begin
         logic [31:0] down;
         down = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 100000);
         load_envelope(pick_length(), pick_length(), pick_length(), pick_level(),
                       pick_level(), down, down + $urandom_range(0, 300000),
                       ($urandom_range(0, 9) == 0));
         random_burst(165);
      end

      drain();
      $display("Checked %0d results over %0d note times and %0d register settings,",
               checked, sent, settings_run);
      $display("with sender gaps and receiver stalls in both proportions and none.");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/adsr_pkg.sv
rtl/core/adsr_div.sv
rtl/core/adsr_envelope.sv
verif/adsr_checker.sv
verif/testbench.sv
